// ----- rtl/langton_ant_step_macros.svh -----
// Assertion macros for the langton_ant_step block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef LANGTON_ANT_STEP_MACROS_SVH
`define LANGTON_ANT_STEP_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold on every clock edge outside reset.
`define LAT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define LAT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LAT_ASSERT(label, clk, rst_n, prop, msg)

`define LAT_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/lat_pkg.sv -----
// Shared types and constants for the Langton's ant step engine.
// No dependencies; used by lat_move and langton_ant_step.
package lat_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int GRID_CNT_W = 7;   // width of the rows/columns-in-use registers
	localparam int FIELD_W    = 6;   // width of row/column fields on the ports
	localparam int NUM_TRIES  = 4;

	// command modes
	localparam logic [1:0] MODE_STEP    = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// headings
	localparam logic [1:0] HD_NORTH = 2'd0;
	localparam logic [1:0] HD_EAST  = 2'd1;
	localparam logic [1:0] HD_SOUTH = 2'd2;
	localparam logic [1:0] HD_WEST  = 2'd3;

	// heading increments, modulo four
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_LEFT  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd4;

	localparam logic [GRID_CNT_W-1:0] NUM_ROWS_RST = 7'd64;
	localparam logic [GRID_CNT_W-1:0] NUM_COLS_RST = 7'd64;
	localparam logic [GRID_CNT_W-1:0] GRID_MIN     = 7'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FIELD_W-1:0] cell_row;
		logic [FIELD_W-1:0] cell_col;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0] ant_row;
		logic [FIELD_W-1:0] ant_col;
		logic [1:0]         heading;
		logic               under_color;
		logic               read_color;
		logic               read_is_ant;
	} res_t;

	// outcome of one turn-and-move try
	typedef struct packed {
		logic       legal;
		logic [1:0] dir;
	} turn_t;

endpackage

// ----- rtl/lat_move.sv -----
// Turn-and-bound unit: one turn try of the ant per cycle, reused by the sequencer.
// Depends on lat_pkg.
module lat_move #(
	parameter int ROW_W = 6,
	parameter int COL_W = 6
) (
	input  logic [ROW_W-1:0]              pos_row,
	input  logic [COL_W-1:0]              pos_col,
	input  logic [1:0]                    dir,
	input  logic                          color,
	input  logic [lat_pkg::GRID_CNT_W-1:0] rows,
	input  logic [lat_pkg::GRID_CNT_W-1:0] cols,
	output lat_pkg::turn_t                turn,
	output logic [ROW_W-1:0]              nr,
	output logic [COL_W-1:0]              nc
);
	import lat_pkg::*;

	localparam int MW = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int XW = ((MW > GRID_CNT_W) ? MW : GRID_CNT_W) + 1;

	logic [1:0]    d_new;
	logic [XW-1:0] nr_x;
	logic [XW-1:0] nc_x;
	logic          fwd_ok;

	always_comb begin
		d_new  = dir + (color ? TURN_LEFT : TURN_RIGHT);
		nr_x   = XW'(pos_row);
		nc_x   = XW'(pos_col);
		fwd_ok = 1'b1;
		case (d_new)
			HD_NORTH: begin
				if (pos_row == '0) fwd_ok = 1'b0;
				else nr_x = XW'(pos_row) - XW'(1);
			end
			HD_EAST: nc_x = XW'(pos_col) + XW'(1);
			HD_SOUTH: nr_x = XW'(pos_row) + XW'(1);
			default: begin
				if (pos_col == '0) fwd_ok = 1'b0;
				else nc_x = XW'(pos_col) - XW'(1);
			end
		endcase
		// a move from outside a shrunken grid is legal only if it lands back inside
		turn.legal = fwd_ok && (nr_x < XW'(rows)) && (nc_x < XW'(cols));
		turn.dir   = d_new;
		nr         = nr_x[ROW_W-1:0];
		nc         = nc_x[COL_W-1:0];
	end

endmodule

// ----- rtl/lat_grid.sv -----
// One-bit cell memory: one write port, one read port with registered data.
// No package dependencies.
module lat_grid #(
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_data
);

	logic mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/langton_ant_step.sv -----
// Langton's ant step engine: command sequencer, cell memory and turn unit.
// Depends on lat_pkg, lat_move, lat_grid and langton_ant_step_macros.svh.
//
// One command is taken when start is high and busy is low; its single result
// appears on res for one cycle with done high and cannot be stalled. A step
// tries one heading per cycle in the shared turn unit and then waits in ST_LOAD
// for the new cell's color from the memory read port; when no legal move exists
// it reports after the last try. A cell read passes through ST_READ, and an
// unused mode reports straight from idle. Restart, and reset itself, sweep the
// cell memory one entry per cycle, over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS))
// entries (4096 at the default size), with busy high throughout; restart then
// reports as the sweep ends. Configuration writes are always ready.
module langton_ant_step #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  lat_pkg::cmd_t                  cmd,
	output logic                           done,
	output lat_pkg::res_t                  res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lat_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lat_pkg::*;

	`include "langton_ant_step_macros.svh"

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int MW = (RW > CW) ? RW : CW;
	localparam int XW = ((MW > GRID_CNT_W) ? MW : GRID_CNT_W) + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TRY   = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	localparam logic [1:0] LAST_TRY = 2'(NUM_TRIES - 1);

	// configuration
	logic [GRID_CNT_W-1:0] num_rows_q, num_cols_q;
	logic [FIELD_W-1:0]    start_row_q, start_col_q;
	logic [1:0]            start_heading_q;

	// control and ant state
	logic [2:0]    state_q;
	logic [1:0]    try_q;
	logic [AW-1:0] clr_q;
	logic          pend_q;
	logic          done_q;
	logic          rcol_q, rant_q;
	logic [RW-1:0] pos_row_q;
	logic [CW-1:0] pos_col_q;
	logic [1:0]    dir_q;
	logic          cur_q;

	// working registers
	logic [1:0]         d_q;
	logic [FIELD_W-1:0] qry_row_q, qry_col_q;

	logic [GRID_CNT_W-1:0] rows_w, cols_w;
	logic [RW-1:0]         start_row_w;
	logic [CW-1:0]         start_col_w;
	logic                  qry_hit, qry_in;

	turn_t         turn;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;

	logic          grid_we, grid_wdata, grid_re, grid_rdata;
	logic [AW-1:0] grid_waddr, grid_raddr;

	// grid size in use, saturated to [2, MAX]
	always_comb begin
		if (num_rows_q < GRID_MIN) rows_w = GRID_MIN;
		else if (XW'(num_rows_q) > XW'(MAX_ROWS)) rows_w = GRID_CNT_W'(MAX_ROWS);
		else rows_w = num_rows_q;
		if (num_cols_q < GRID_MIN) cols_w = GRID_MIN;
		else if (XW'(num_cols_q) > XW'(MAX_COLS)) cols_w = GRID_CNT_W'(MAX_COLS);
		else cols_w = num_cols_q;
	end

	assign start_row_w = (XW'(start_row_q) < XW'(rows_w)) ? RW'(start_row_q)
	                                                     : RW'(rows_w - GRID_CNT_W'(1));
	assign start_col_w = (XW'(start_col_q) < XW'(cols_w)) ? CW'(start_col_q)
	                                                     : CW'(cols_w - GRID_CNT_W'(1));

	assign qry_hit = (XW'(qry_row_q) == XW'(pos_row_q)) && (XW'(qry_col_q) == XW'(pos_col_q));
	assign qry_in  = (XW'(qry_row_q) < XW'(rows_w)) && (XW'(qry_col_q) < XW'(cols_w));

	lat_move #(
		.ROW_W (RW),
		.COL_W (CW)
	) u_move (
		.pos_row (pos_row_q),
		.pos_col (pos_col_q),
		.dir     (d_q),
		.color   (cur_q),
		.rows    (rows_w),
		.cols    (cols_w),
		.turn    (turn),
		.nr      (nr),
		.nc      (nc)
	);

	// memory port steering
	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = {pos_row_q, pos_col_q};
		grid_wdata = ~cur_q;
		grid_re    = 1'b0;
		grid_raddr = {nr, nc};
		case (state_q)
			ST_IDLE: begin
				grid_re    = start && (cmd.mode == MODE_READ);
				grid_raddr = {RW'(cmd.cell_row), CW'(cmd.cell_col)};
			end
			ST_TRY: begin
				// leave the old cell flipped, fetch the color of the new one
				grid_we = turn.legal;
				grid_re = turn.legal;
			end
			ST_CLEAR: begin
				grid_we    = 1'b1;
				grid_waddr = clr_q;
				grid_wdata = 1'b0;
			end
			default: ;
		endcase
	end

	lat_grid #(
		.ADDR_W (AW)
	) u_grid (
		.clk     (clk),
		.wr_en   (grid_we),
		.wr_addr (grid_waddr),
		.wr_data (grid_wdata),
		.rd_en   (grid_re),
		.rd_addr (grid_raddr),
		.rd_data (grid_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q      <= NUM_ROWS_RST;
			num_cols_q      <= NUM_COLS_RST;
			start_row_q     <= '0;
			start_col_q     <= '0;
			start_heading_q <= HD_NORTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_ROWS:      num_rows_q      <= cfg_data;
				CFG_NUM_COLS:      num_cols_q      <= cfg_data;
				CFG_START_ROW:     start_row_q     <= cfg_data[FIELD_W-1:0];
				CFG_START_COL:     start_col_q     <= cfg_data[FIELD_W-1:0];
				CFG_START_HEADING: start_heading_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;   // memory sweep after reset
			try_q     <= '0;
			clr_q     <= '0;
			pend_q    <= 1'b0;
			done_q    <= 1'b0;
			rcol_q    <= 1'b0;
			rant_q    <= 1'b0;
			pos_row_q <= '0;
			pos_col_q <= '0;
			dir_q     <= HD_NORTH;
			cur_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd.mode)
							MODE_STEP: begin
								try_q   <= '0;
								state_q <= ST_TRY;
							end
							MODE_READ: state_q <= ST_READ;
							MODE_RESTART: begin
								pos_row_q <= start_row_w;
								pos_col_q <= start_col_w;
								dir_q     <= start_heading_q;
								cur_q     <= 1'b0;
								clr_q     <= '0;
								pend_q    <= 1'b1;
								state_q   <= ST_CLEAR;
							end
							default: begin
								rcol_q <= 1'b0;
								rant_q <= 1'b0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_TRY: begin
					if (turn.legal) begin
						pos_row_q <= nr;
						pos_col_q <= nc;
						dir_q     <= turn.dir;
						state_q   <= ST_LOAD;
					end else begin
						try_q <= try_q + 2'd1;
						if (try_q == LAST_TRY) begin
							// full circle: heading and grid unchanged
							rcol_q  <= 1'b0;
							rant_q  <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LOAD: begin
					cur_q   <= grid_rdata;
					rcol_q  <= 1'b0;
					rant_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					// the ant's own cell color lives in cur_q, not in memory
					rant_q  <= qry_hit;
					rcol_q  <= qry_hit ? cur_q : (qry_in & grid_rdata);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						rcol_q  <= 1'b0;
						rant_q  <= 1'b0;
						done_q  <= pend_q;
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			d_q       <= dir_q;
			qry_row_q <= cmd.cell_row;
			qry_col_q <= cmd.cell_col;
		end else if (state_q == ST_TRY) begin
			d_q <= turn.dir;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign cfg_ready = 1'b1;

	assign res.ant_row     = FIELD_W'(pos_row_q);
	assign res.ant_col     = FIELD_W'(pos_col_q);
	assign res.heading     = dir_q;
	assign res.under_color = cur_q;
	assign res.read_color  = rcol_q;
	assign res.read_is_ant = rant_q;

	`LAT_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result strobe while busy")
	`LAT_ASSERT(a_accept_acts, clk, arst_n,
		(start && !busy) |=> (busy || done), "command transfer had no effect")
	`LAT_ASSERT(a_load_after_try, clk, arst_n,
		(state_q == ST_LOAD) |-> $past(state_q == ST_TRY), "cell load without a legal try")
	`LAT_ASSERT_NEVER(a_port_clash, clk, arst_n,
		grid_we && grid_re && (grid_waddr == grid_raddr), "grid read and write hit one cell")
	`LAT_ASSERT(a_single_done, clk, arst_n,
		(done && !(start && !busy)) |=> !done, "result strobe repeated without a transfer")

endmodule

// ----- verif/langton_ant_step_test.sv -----
// Self-checking testbench for langton_ant_step: directed and random command streams,
// config writes between phases, results checked in order against an in-bench ant model.
// Depends on lat_pkg and the langton_ant_step RTL.
module langton_ant_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lat_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int GRID_ROWS   = 64;
	localparam int GRID_COLS   = 64;
	localparam int WALK_ITEMS  = 590;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 20;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	cmd_t                  cmd       = '0;
	logic                  done;
	res_t                  res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// ant and grid as the block should hold them
	bit                    cell_map [GRID_ROWS][GRID_COLS];
	int                    ant_r     = 0;
	int                    ant_c     = 0;
	logic [1:0]            ant_dir   = HD_NORTH;
	bit                    ant_color = 1'b0;
	logic [GRID_CNT_W-1:0] rows_cfg  = NUM_ROWS_RST;
	logic [GRID_CNT_W-1:0] cols_cfg  = NUM_COLS_RST;
	logic [FIELD_W-1:0]    srow_cfg  = '0;
	logic [FIELD_W-1:0]    scol_cfg  = '0;
	logic [1:0]            shead_cfg = HD_NORTH;

	res_t ant_reports [$];
	res_t want_res;

	int mismatches   = 0;
	int results_seen = 0;
	int cfg_writes   = 0;
	int walk_items   = 0;
	int cycle_count  = 0;
	int mode_count [4];
	bit no_gaps      = 1'b0;

	langton_ant_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int clamp_grid(input int n, input int top);
		if (n < GRID_MIN) return GRID_MIN;
		if (n > top) return top;
		return n;
	endfunction

	function automatic cmd_t make_cmd(input logic [1:0] m, input logic [5:0] r,
			input logic [5:0] c);
		cmd_t t;
		t.mode     = m;
		t.cell_row = r;
		t.cell_col = c;
		return t;
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_gaps) return 0;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic step_ant();
		int         rows;
		int         cols;
		int         nr;
		int         nc;
		bit         ok;
		logic [1:0] d;
		rows = clamp_grid(rows_cfg, GRID_ROWS);
		cols = clamp_grid(cols_cfg, GRID_COLS);
		d    = ant_dir;
		for (int t = 0; t < NUM_TRIES; t++) begin
			d  = d + (ant_color ? TURN_LEFT : TURN_RIGHT);
			nr = ant_r;
			nc = ant_c;
			ok = 1'b1;
			case (d)
				HD_NORTH: begin
					if (ant_r == 0) ok = 1'b0;
					else nr = ant_r - 1;
				end
				HD_EAST:  nc = ant_c + 1;
				HD_SOUTH: nr = ant_r + 1;
				default: begin
					if (ant_c == 0) ok = 1'b0;
					else nc = ant_c - 1;
				end
			endcase
			if (ok && nr < rows && nc < cols) begin
				cell_map[ant_r][ant_c] = ~ant_color;
				ant_color = cell_map[nr][nc];
				ant_r     = nr;
				ant_c     = nc;
				ant_dir   = d;
				return;
			end
		end
		// boxed in: four turns leave the heading where it was
	endtask

	task automatic restart_ant();
		int rows;
		int cols;
		rows = clamp_grid(rows_cfg, GRID_ROWS);
		cols = clamp_grid(cols_cfg, GRID_COLS);
		foreach (cell_map[i, j]) cell_map[i][j] = 1'b0;
		ant_r     = (srow_cfg < rows) ? int'(srow_cfg) : rows - 1;
		ant_c     = (scol_cfg < cols) ? int'(scol_cfg) : cols - 1;
		ant_dir   = shead_cfg;
		ant_color = 1'b0;
	endtask

	// updates the ant model for one accepted command and queues the report it gives
	task automatic compute_ant_report(input cmd_t c);
		res_t r;
		bit   rd_color;
		bit   rd_ant;
		rd_color = 1'b0;
		rd_ant   = 1'b0;
		case (c.mode)
			MODE_STEP: step_ant();
			MODE_READ: begin
				if (c.cell_row == ant_r && c.cell_col == ant_c) begin
					rd_ant   = 1'b1;
					rd_color = ant_color;
				end else if (c.cell_row < clamp_grid(rows_cfg, GRID_ROWS) &&
						c.cell_col < clamp_grid(cols_cfg, GRID_COLS)) begin
					rd_color = cell_map[c.cell_row][c.cell_col];
				end
			end
			MODE_RESTART: restart_ant();
			default: ;
		endcase
		r.ant_row     = ant_r[FIELD_W-1:0];
		r.ant_col     = ant_c[FIELD_W-1:0];
		r.heading     = ant_dir;
		r.under_color = ant_color;
		r.read_color  = rd_color;
		r.read_is_ant = rd_ant;
		ant_reports.push_back(r);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string fname, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) note_mismatch($sformatf("%s expected %0d, got %0d", fname, want, got));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (ant_reports.size() == 0) begin
				note_mismatch($sformatf("result %h with nothing expected", res));
			end else begin
				want_res = ant_reports.pop_front();
				check_field("ant_row", 8'(res.ant_row), 8'(want_res.ant_row));
				check_field("ant_col", 8'(res.ant_col), 8'(want_res.ant_col));
				check_field("heading", 8'(res.heading), 8'(want_res.heading));
				check_field("under_color", 8'(res.under_color), 8'(want_res.under_color));
				check_field("read_color", 8'(res.read_color), 8'(want_res.read_color));
				check_field("read_is_ant", 8'(res.read_is_ant), 8'(want_res.read_is_ant));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// start stays high when the next command follows with no gap
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		compute_ant_report(c);
		mode_count[c.mode]++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (ant_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NUM_ROWS:      rows_cfg  = val;
			CFG_NUM_COLS:      cols_cfg  = val;
			CFG_START_ROW:     srow_cfg  = val[FIELD_W-1:0];
			CFG_START_COL:     scol_cfg  = val[FIELD_W-1:0];
			CFG_START_HEADING: shead_cfg = val[1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// back-to-back transfers on the config channel, valid dropped after the last
	task automatic program_grid(input logic [6:0] rows, input logic [6:0] cols,
			input logic [6:0] srow, input logic [6:0] scol, input logic [6:0] shead);
		write_cfg(CFG_NUM_ROWS, rows);
		write_cfg(CFG_NUM_COLS, cols);
		write_cfg(CFG_START_ROW, srow);
		write_cfg(CFG_START_COL, scol);
		write_cfg(CFG_START_HEADING, shead);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_cmd(make_cmd(MODE_READ, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_READ, 6'd63, 6'd63));
		send_cmd(make_cmd(MODE_UNUSED, 6'd63, 6'd63));
		repeat (2) send_cmd(make_cmd(MODE_STEP, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_READ, 6'd0, 6'd0));
		settle();
	endtask

	task automatic test_grid_limits();
		// sizes below two and above the array saturate
		program_grid(7'd0, 7'd1, 7'd0, 7'd0, 7'(HD_WEST));
		send_cmd(make_cmd(MODE_RESTART, 6'd0, 6'd0));
		repeat (4) send_cmd(make_cmd(MODE_STEP, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_READ, 6'd1, 6'd1));
		settle();
		program_grid(7'd127, 7'd127, 7'd63, 7'd63, 7'(HD_EAST));
		send_cmd(make_cmd(MODE_RESTART, 6'd63, 6'd63));
		repeat (2) send_cmd(make_cmd(MODE_STEP, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_READ, 6'd63, 6'd63));
		settle();
	endtask

	task automatic test_start_clamp();
		program_grid(7'd10, 7'd5, 7'd63, 7'd127, 7'(HD_SOUTH));
		send_cmd(make_cmd(MODE_RESTART, 6'd0, 6'd0));
		repeat (2) send_cmd(make_cmd(MODE_STEP, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_READ, 6'd20, 6'd20));
		send_cmd(make_cmd(MODE_READ, 6'd9, 6'd0));
		settle();
	endtask

	task automatic test_stuck_ant();
		program_grid(7'd64, 7'd64, 7'd40, 7'd30, 7'(HD_NORTH));
		send_cmd(make_cmd(MODE_RESTART, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_STEP, 6'd0, 6'd0));
		settle();
		// shrink the grid under the ant: it has nowhere to go
		program_grid(7'd2, 7'd2, 7'd40, 7'd30, 7'(HD_NORTH));
		send_cmd(make_cmd(MODE_STEP, 6'd0, 6'd0));
		send_cmd(make_cmd(MODE_READ, 6'(ant_r), 6'(ant_c)));
		send_cmd(make_cmd(MODE_READ, 6'd40, 6'd30));
		settle();
	endtask

	task automatic test_random_walk();
		int         p;
		int         rows;
		int         cols;
		int         srow;
		int         scol;
		int         len;
		logic [5:0] r;
		logic [5:0] c;
		while (walk_items < WALK_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 15) begin
				rows = $urandom_range(0, 127);
				cols = $urandom_range(0, 127);
			end else if (p < 45) begin
				rows = $urandom_range(2, 8);
				cols = $urandom_range(2, 8);
			end else begin
				rows = $urandom_range(2, GRID_ROWS);
				cols = $urandom_range(2, GRID_COLS);
			end
			srow = $urandom_range(0, 1) ? $urandom_range(0, 127)
				: $urandom_range(0, clamp_grid(rows, GRID_ROWS) - 1);
			scol = $urandom_range(0, 1) ? $urandom_range(0, 127)
				: $urandom_range(0, clamp_grid(cols, GRID_COLS) - 1);
			program_grid(7'(rows), 7'(cols), 7'(srow), 7'(scol), 7'($urandom_range(0, 127)));
			no_gaps = ($urandom_range(0, 3) == 0);
			// without a restart the ant keeps its place, possibly off the new grid
			if ($urandom_range(0, 9) < 7) begin
				send_cmd(make_cmd(MODE_RESTART, 6'($urandom), 6'($urandom)));
				walk_items++;
			end
			len = $urandom_range(40, 90);
			repeat (len) begin
				p = $urandom_range(0, 99);
				if (p < 62) begin
					send_cmd(make_cmd(MODE_STEP, 6'($urandom), 6'($urandom)));
					walk_items++;
				end else if (p < 93) begin
					p = $urandom_range(0, 99);
					if (p < 35) begin
						r = 6'(ant_r + int'($urandom_range(0, 2)) - 1);
						c = 6'(ant_c + int'($urandom_range(0, 2)) - 1);
					end else if (p < 80) begin
						r = 6'($urandom_range(0, clamp_grid(rows_cfg, GRID_ROWS) - 1));
						c = 6'($urandom_range(0, clamp_grid(cols_cfg, GRID_COLS) - 1));
					end else begin
						r = 6'($urandom_range(0, 63));
						c = 6'($urandom_range(0, 63));
					end
					send_cmd(make_cmd(MODE_READ, r, c));
					walk_items++;
				end else if (p < 97) begin
					send_cmd(make_cmd(MODE_UNUSED, 6'($urandom), 6'($urandom)));
				end else begin
					send_cmd(make_cmd(MODE_RESTART, 6'($urandom), 6'($urandom)));
					walk_items++;
				end
			end
			settle();
		end
		no_gaps = 1'b0;
	endtask

	initial begin : main_seq
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset clears the cell memory with busy high
		while (busy) @(posedge clk);
		test_reset_state();
		test_grid_limits();
		test_start_clamp();
		test_stuck_ant();
		test_random_walk();
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ant_reports.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", ant_reports.size()));
		$display("Ran %0d steps, %0d cell reads, %0d restarts, %0d unused-mode commands",
			mode_count[MODE_STEP], mode_count[MODE_READ], mode_count[MODE_RESTART],
			mode_count[MODE_UNUSED]);
		$display("with %0d config writes; %0d results checked, %0d mismatches.",
			cfg_writes, results_seen, mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lat_pkg.sv
rtl/lat_move.sv
rtl/lat_grid.sv
rtl/langton_ant_step.sv
verif/langton_ant_step_test.sv
